[sv/usf_pkg.sv]
package usf_pkg;

  // Width of the saturating position counter
  localparam int unsigned PosW = 16;
  // Width of the reported offsets
  localparam int unsigned OutW = 16;
  // Width used when narrowing a position to an offset
  localparam int unsigned ExtW = (PosW > OutW) ? PosW : OutW;

  localparam int unsigned CharW = 8;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 2 * OutW;

  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;

  // Progress through the "://" separator
  typedef enum logic [1:0] {
    SEP_IDLE   = 2'd0,
    SEP_COLON  = 2'd1,
    SEP_SLASH1 = 2'd2,
    SEP_SLASH2 = 2'd3
  } sep_e;

  // Classification of one text byte
  typedef struct packed {
    logic letter;
    logic url;
    logic colon;
    logic slash;
  } char_class_t;

  // Punctuation allowed inside a URL
  function automatic logic is_special(input logic [CharW-1:0] c);
    logic hit;
    unique case (c)
      "~", ";", "/", "?", ":", "@", "=", "&", "$", "-",
      "_", ".", "+", "!", "*", "'", "(", ")", ",": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

[sv/usf_classify.sv]
module usf_classify (
  input  logic [usf_pkg::CharW-1:0] char_i,
  output usf_pkg::char_class_t      class_o
);
  import usf_pkg::*;

  logic is_upper, is_lower, is_digit;

  // ASCII ranges; bytes from 128 up fall in none of them
  assign is_upper = (char_i >= "A") && (char_i <= "Z");
  assign is_lower = (char_i >= "a") && (char_i <= "z");
  assign is_digit = (char_i >= "0") && (char_i <= "9");

  assign class_o.letter = is_upper | is_lower;
  assign class_o.url    = is_upper | is_lower | is_digit | is_special(char_i);
  assign class_o.colon  = (char_i == ChColon);
  assign class_o.slash  = (char_i == ChSlash);

endmodule

[sv/usf_scan.sv]
module usf_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  usf_pkg::char_class_t     class_i,
  input  logic                     last_i,
  output logic                     res_vld_o,
  output logic [usf_pkg::OutW-1:0] res_start_o,
  output logic [usf_pkg::OutW-1:0] res_end_o
);
  import usf_pkg::*;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  logic [PosW-1:0] run_start_q, run_start_d;
  logic            run_nz_q, run_nz_d;
  logic [PosW-1:0] cand_start_q, cand_start_d;
  logic            cand_ok_q, cand_ok_d;
  sep_e            sep_q, sep_d;
  logic            in_url_q, in_url_d;
  logic [PosW-1:0] url_start_q, url_start_d;
  logic            idle_scan;
  logic [PosW-1:0] res_start_pos, res_end_pos;

  assign pos_inc = (pos_q == PosMax) ? PosMax : pos_q + 1'b1;

  // Next state for one item, and its result if any
  always_comb begin
    run_start_d   = run_start_q;
    run_nz_d      = run_nz_q;
    cand_start_d  = cand_start_q;
    cand_ok_d     = cand_ok_q;
    sep_d         = sep_q;
    in_url_d      = in_url_q;
    url_start_d   = url_start_q;
    idle_scan     = 1'b0;
    res_vld_o     = 1'b0;
    res_start_pos = url_start_q;
    res_end_pos   = pos_inc;

    if (in_url_q) begin
      if (class_i.url) begin
        res_vld_o = last_i;
      end else begin
        res_vld_o   = 1'b1;
        res_end_pos = pos_q;
        in_url_d    = 1'b0;
        idle_scan   = 1'b1;
      end
    end else begin
      unique case (sep_q)
        SEP_COLON: begin
          if (class_i.slash) begin
            sep_d    = SEP_SLASH1;
            run_nz_d = 1'b0;
          end else begin
            sep_d     = SEP_IDLE;
            idle_scan = 1'b1;
          end
        end
        SEP_SLASH1: begin
          if (class_i.slash) begin
            sep_d    = SEP_SLASH2;
            run_nz_d = 1'b0;
          end else begin
            sep_d     = SEP_IDLE;
            idle_scan = 1'b1;
          end
        end
        SEP_SLASH2: begin
          sep_d = SEP_IDLE;
          if (cand_ok_q && class_i.url) begin
            in_url_d      = 1'b1;
            url_start_d   = cand_start_q;
            run_nz_d      = 1'b0;
            res_vld_o     = last_i;
            res_start_pos = cand_start_q;
          end else begin
            idle_scan = 1'b1;
          end
        end
        default: idle_scan = 1'b1;
      endcase
    end

    // Letter run tracking and separator start
    if (idle_scan) begin
      if (class_i.letter) begin
        if (!run_nz_q) begin
          run_start_d = pos_q;
          run_nz_d    = 1'b1;
        end
      end else begin
        if (class_i.colon) begin
          cand_start_d = run_start_q;
          cand_ok_d    = run_nz_q;
          sep_d        = SEP_COLON;
        end
        run_nz_d = 1'b0;
      end
    end

    pos_d = pos_inc;

    // End of text returns everything to reset values
    if (last_i) begin
      pos_d        = '0;
      run_start_d  = '0;
      run_nz_d     = 1'b0;
      cand_start_d = '0;
      cand_ok_d    = 1'b0;
      sep_d        = SEP_IDLE;
      in_url_d     = 1'b0;
      url_start_d  = '0;
    end
  end

  assign res_start_o = OutW'(ExtW'(res_start_pos));
  assign res_end_o   = OutW'(ExtW'(res_end_pos));

  // Scan state, advanced once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      run_start_q  <= '0;
      run_nz_q     <= 1'b0;
      cand_start_q <= '0;
      cand_ok_q    <= 1'b0;
      sep_q        <= SEP_IDLE;
      in_url_q     <= 1'b0;
      url_start_q  <= '0;
    end else if (adv_i) begin
      pos_q        <= pos_d;
      run_start_q  <= run_start_d;
      run_nz_q     <= run_nz_d;
      cand_start_q <= cand_start_d;
      cand_ok_q    <= cand_ok_d;
      sep_q        <= sep_d;
      in_url_q     <= in_url_d;
      url_start_q  <= url_start_d;
    end
  end

  // A separator match and an open URL never coexist
  a_sep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_url_q |-> (sep_q == SEP_IDLE))
    else $error("separator match active inside URL");

  // No letter run is open while a URL is being read
  a_run_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_url_q |-> !run_nz_q)
    else $error("letter run open inside URL");

  // Last byte of a text clears the position counter
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && last_i) |=> (pos_q == '0) && !in_url_q && (sep_q == SEP_IDLE))
    else $error("state not cleared after last byte");

  // A URL start never lies after its end
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res_vld_o) |-> (res_start_pos <= res_end_pos))
    else $error("URL start after URL end");

endmodule

[sv/url_span_finder_unit.sv]
// Channel  | Direction | tdata                                   | Other
// s_axis   | in        | [7:0] text_char                         | tlast = last_char
// m_axis   | out       | [15:0] url_start, [31:16] url_end       | -
//
// One byte is taken per cycle while no result is held at the output; it sits
// in the input register while its scan step runs, and a URL it closes is
// loaded into the output register when that scan step advances.
// Reset clears all scan state and the valid flags of both register stages.
// A held result stalls the scan step, so the input takes at most one more byte;
// while the output drains, the input register still takes a new byte.
module url_span_finder_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [usf_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] text_char
  input  logic                         s_axis_tlast,  // last_char
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [usf_pkg::OutDataW-1:0] m_axis_tdata   // [15:0] url_start, [31:16] url_end
);
  import usf_pkg::*;

  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;
  logic             adv;
  char_class_t      char_class;
  logic             res_vld;
  logic [OutW-1:0]  res_start, res_end;
  logic             out_vld_q, out_vld_d;
  logic [OutW-1:0]  out_start_q, out_end_q;

  // Scan step runs when the output stage can take its result
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_vld_d      = s_axis_tvalid || (in_vld_q && !adv);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata[CharW-1:0];
      in_last_q <= s_axis_tlast;
    end
  end

  usf_classify u_classify (
    .char_i  (in_char_q),
    .class_o (char_class)
  );

  usf_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .class_i     (char_class),
    .last_i      (in_last_q),
    .res_vld_o   (res_vld),
    .res_start_o (res_start),
    .res_end_o   (res_end)
  );

  // Output register
  always_comb begin
    if (adv) begin
      out_vld_d = res_vld;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_start_q <= res_start;
      out_end_q   <= res_end;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_end_q, out_start_q};

endmodule
